FILE: sv/lob_pkg.sv
package lob_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOK_RD,
        ST_FOK_CHK,
        ST_MT_RD,
        ST_MT_CHK,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_WR,
        ST_SUMMARY
    } t_state;

    localparam logic [1:0] TIF_GTC = 2'd0;
    localparam logic [1:0] TIF_IOC = 2'd1;
    localparam logic [1:0] TIF_FOK = 2'd2;

    // one resting entry
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] id;
    } t_entry;

    // memory port commands from the sequencer
    typedef struct packed {
        logic        rd_en;
        logic        rd_ask;
        logic        wr_en;
        logic        wr_ask;
    } t_mem_ctl;

endpackage

FILE: sv/lob_store.sv
// both sides of the book, one read port and one write port
module lob_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  lob_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  lob_pkg::t_entry   i_wr_data,
    output lob_pkg::t_entry   o_rd_data
);

    lob_pkg::t_entry r_bid [DEPTH];
    lob_pkg::t_entry r_ask [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            if (i_ctl.wr_ask) r_ask[i_wr_addr] <= i_wr_data;
            else              r_bid[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= i_ctl.rd_ask ? r_ask[i_rd_addr] : r_bid[i_rd_addr];
        end
    end

endmodule

FILE: sv/limit_order_book_matcher_unit.sv
// Order matcher: one order is taken when start is high and busy low, and busy
// stays high until its summary beat has gone out. Results appear for one
// cycle each with o_valid and cannot be held off. The entries of a side sit
// in one memory with a registered read port, and one sequencer walks them:
// an FOK pre-check reads and sums entries one by one, each fill reads and
// checks the best entry, a fully consumed best entry shifts the rest forward
// one by one, and resting a remainder searches from the back, shifting worse
// entries back, then writes. A zero-quantity order goes straight to its
// summary; a sweep of a full side keeps busy high longest, since every
// consumed entry shifts the rest forward.
module limit_order_book_matcher_unit #(
    parameter int BOOK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_order_id,
    input  logic        i_buy_side,
    input  logic        i_is_market,
    input  logic [1:0]  i_time_in_force,
    input  logic        i_market_to_limit,
    input  logic [31:0] i_limit_price,
    input  logic [31:0] i_order_qty,
    input  logic [47:0] i_timestamp,
    output logic        o_valid,
    output logic        o_is_summary,
    output logic [31:0] o_trade_id,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_trade_qty,
    output logic [31:0] o_maker_id,
    output logic [31:0] o_taker_id,
    output logic [47:0] o_trade_time,
    output logic [31:0] o_filled_qty,
    output logic        o_killed,
    output logic        o_rested,
    output logic [31:0] o_rest_price,
    output logic        o_last
);

    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam logic [CW-1:0] FULL = CW'(BOOK_DEPTH);

    lob_pkg::t_state r_state, n_state;

    logic [31:0] r_id, r_limit, r_qty, r_rem, r_last_px, r_rest_px, r_trade_no;
    logic [47:0] r_ts;
    logic        r_buy, r_mkt, r_mtl, r_killed, r_rested, r_traded;
    logic [1:0]  r_tif;
    logic [32:0] r_avail;
    logic [CW-1:0] r_bid_cnt, r_ask_cnt, r_idx;
    logic [31:0] n_rem, n_last_px, n_rest_px, n_trade_no;
    logic        n_killed, n_rested, n_traded;
    logic [32:0] n_avail;
    logic [CW-1:0] n_bid_cnt, n_ask_cnt, n_idx;

    lob_pkg::t_mem_ctl mem_ctl;
    logic [CW-1:0]     rd_idx, wr_idx;
    lob_pkg::t_entry   wr_data, rd_data;

    logic [CW-1:0] opp_cnt, own_cnt;
    logic          beyond, fill_q_lt, worse;
    logic [31:0]   fill_q;
    logic          want_rest;

    lob_store #(.DEPTH(BOOK_DEPTH), .AW(AW)) u_store (
        .i_clk    (i_clk),
        .i_ctl    (mem_ctl),
        .i_rd_addr(rd_idx[AW-1:0]),
        .i_wr_addr(wr_idx[AW-1:0]),
        .i_wr_data(wr_data),
        .o_rd_data(rd_data)
    );

    assign opp_cnt = r_buy ? r_ask_cnt : r_bid_cnt;
    assign own_cnt = r_buy ? r_bid_cnt : r_ask_cnt;
    assign beyond  = !r_mkt && (r_buy ? (rd_data.price > r_limit)
                                      : (rd_data.price < r_limit));
    assign fill_q_lt = r_rem < rd_data.qty;
    assign fill_q  = fill_q_lt ? r_rem : rd_data.qty;
    // insertion comparison on the resting side
    assign worse   = r_buy ? (rd_data.price < r_rest_px) : (rd_data.price > r_rest_px);
    assign want_rest = r_mkt ? (r_mtl && r_traded) : (r_tif != lob_pkg::TIF_IOC);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lob_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_order_qty == 32'd0)                 n_state = lob_pkg::ST_SUMMARY;
                    else if (i_time_in_force == lob_pkg::TIF_FOK) n_state = lob_pkg::ST_FOK_RD;
                    else                                      n_state = lob_pkg::ST_MT_RD;
                end
            end
            lob_pkg::ST_FOK_RD: begin
                if (r_idx >= opp_cnt) n_state = lob_pkg::ST_SUMMARY;
                else                  n_state = lob_pkg::ST_FOK_CHK;
            end
            lob_pkg::ST_FOK_CHK: begin
                if (beyond) n_state = lob_pkg::ST_SUMMARY;
                else if ({1'b0, r_avail[31:0]} + {1'b0, rd_data.qty} + {32'd0, r_avail[32]}
                         >= 33'(r_qty) || r_avail[32])
                    n_state = lob_pkg::ST_MT_RD;
                else n_state = lob_pkg::ST_FOK_RD;
            end
            lob_pkg::ST_MT_RD: begin
                if (r_rem == 32'd0) n_state = lob_pkg::ST_SUMMARY;
                else if (opp_cnt == '0) n_state = want_rest ? lob_pkg::ST_INS_RD
                                                            : lob_pkg::ST_SUMMARY;
                else n_state = lob_pkg::ST_MT_CHK;
            end
            lob_pkg::ST_MT_CHK: begin
                if (beyond) n_state = want_rest ? lob_pkg::ST_INS_RD : lob_pkg::ST_SUMMARY;
                else if (!fill_q_lt) n_state = lob_pkg::ST_DROP_RD;
                else n_state = lob_pkg::ST_MT_RD;
            end
            lob_pkg::ST_DROP_RD: begin
                if (r_idx > opp_cnt) n_state = lob_pkg::ST_MT_RD;
                else                 n_state = lob_pkg::ST_DROP_WR;
            end
            lob_pkg::ST_DROP_WR: n_state = lob_pkg::ST_DROP_RD;
            lob_pkg::ST_INS_RD: begin
                if (own_cnt >= FULL)  n_state = lob_pkg::ST_SUMMARY;
                else if (r_idx == '0) n_state = lob_pkg::ST_INS_WR;
                else                  n_state = lob_pkg::ST_INS_CHK;
            end
            lob_pkg::ST_INS_CHK: begin
                if (worse) n_state = lob_pkg::ST_INS_RD;
                else       n_state = lob_pkg::ST_INS_WR;
            end
            lob_pkg::ST_INS_WR: n_state = lob_pkg::ST_SUMMARY;
            lob_pkg::ST_SUMMARY: n_state = lob_pkg::ST_IDLE;
            default: n_state = lob_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_rem = r_rem; n_last_px = r_last_px; n_rest_px = r_rest_px;
        n_trade_no = r_trade_no; n_killed = r_killed; n_rested = r_rested;
        n_traded = r_traded; n_avail = r_avail; n_bid_cnt = r_bid_cnt;
        n_ask_cnt = r_ask_cnt; n_idx = r_idx;
        mem_ctl = '0; rd_idx = r_idx; wr_idx = r_idx; wr_data = rd_data;
        o_valid = 1'b0; o_is_summary = 1'b0; o_trade_id = '0; o_trade_price = '0;
        o_trade_qty = '0; o_maker_id = '0; o_taker_id = r_id; o_trade_time = r_ts;
        o_filled_qty = '0; o_killed = 1'b0; o_rested = 1'b0; o_rest_price = '0;
        o_last = 1'b0;
        unique case (r_state)
            lob_pkg::ST_IDLE: begin
                n_idx = '0; n_avail = '0; n_killed = 1'b0; n_rested = 1'b0;
                n_traded = 1'b0; n_rem = i_order_qty;
                n_rest_px = i_limit_price;
            end
            lob_pkg::ST_FOK_RD: begin
                mem_ctl.rd_en = 1'b1; mem_ctl.rd_ask = r_buy;
                if (r_idx >= opp_cnt) n_killed = 1'b1;
            end
            lob_pkg::ST_FOK_CHK: begin
                n_avail = r_avail + {1'b0, rd_data.qty};
                n_idx = r_idx + CW'(1);
                if (beyond) n_killed = 1'b1;
                else if (n_avail >= 33'(r_qty)) n_idx = '0;
            end
            lob_pkg::ST_MT_RD: begin
                mem_ctl.rd_en = 1'b1; mem_ctl.rd_ask = r_buy; rd_idx = '0;
                n_idx = own_cnt;
            end
            lob_pkg::ST_MT_CHK: begin
                if (!beyond) begin
                    o_valid = 1'b1; o_trade_id = r_trade_no; o_trade_price = rd_data.price;
                    o_trade_qty = fill_q; o_maker_id = rd_data.id;
                    n_trade_no = r_trade_no + 32'd1; n_last_px = rd_data.price;
                    n_traded = 1'b1; n_rem = r_rem - fill_q;
                    n_idx = CW'(1);
                    // partial hit on the best entry is written back in place
                    mem_ctl.wr_en = fill_q_lt; mem_ctl.wr_ask = r_buy; wr_idx = '0;
                    wr_data.qty = rd_data.qty - fill_q;
                    if (!fill_q_lt) begin
                        if (r_buy) n_ask_cnt = r_ask_cnt - CW'(1);
                        else       n_bid_cnt = r_bid_cnt - CW'(1);
                    end
                end
                if (beyond || n_rem != '0) begin
                    if (r_mkt) n_rest_px = n_last_px;
                end
            end
            lob_pkg::ST_DROP_RD: begin
                // after the count dropped, entries up to the old count move down
                mem_ctl.rd_en = 1'b1; mem_ctl.rd_ask = r_buy;
                if (r_idx > opp_cnt) n_idx = own_cnt;
            end
            lob_pkg::ST_DROP_WR: begin
                mem_ctl.wr_en = 1'b1; mem_ctl.wr_ask = r_buy; wr_idx = r_idx - CW'(1);
                n_idx = r_idx + CW'(1);
            end
            lob_pkg::ST_INS_RD: begin
                mem_ctl.rd_en = 1'b1; mem_ctl.rd_ask = !r_buy; rd_idx = r_idx - CW'(1);
                if (r_mkt) n_rest_px = r_last_px;
            end
            lob_pkg::ST_INS_CHK: begin
                if (worse) begin
                    mem_ctl.wr_en = 1'b1; mem_ctl.wr_ask = !r_buy;
                    n_idx = r_idx - CW'(1);
                end
            end
            lob_pkg::ST_INS_WR: begin
                mem_ctl.wr_en = 1'b1; mem_ctl.wr_ask = !r_buy;
                wr_data.price = r_rest_px; wr_data.qty = r_rem; wr_data.id = r_id;
                n_rested = 1'b1;
                if (r_buy) n_bid_cnt = r_bid_cnt + CW'(1);
                else       n_ask_cnt = r_ask_cnt + CW'(1);
            end
            lob_pkg::ST_SUMMARY: begin
                o_valid = 1'b1; o_is_summary = 1'b1; o_last = 1'b1;
                o_killed = r_killed; o_rested = r_rested;
                o_filled_qty = r_killed ? 32'd0 : r_qty - r_rem;
                o_rest_price = r_rested ? r_rest_px : 32'd0;
            end
            default: ;
        endcase
    end

    assign busy = (r_state != lob_pkg::ST_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lob_pkg::ST_IDLE;
            r_bid_cnt <= '0;
            r_ask_cnt <= '0;
            r_trade_no <= '0;
        end else begin
            r_state <= n_state;
            r_bid_cnt <= n_bid_cnt;
            r_ask_cnt <= n_ask_cnt;
            r_trade_no <= n_trade_no;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == lob_pkg::ST_IDLE && start) begin
            r_id <= i_order_id; r_buy <= i_buy_side; r_mkt <= i_is_market;
            r_tif <= i_time_in_force; r_mtl <= i_market_to_limit;
            r_limit <= i_limit_price; r_qty <= i_order_qty; r_ts <= i_timestamp;
        end
        r_rem <= n_rem; r_last_px <= n_last_px; r_rest_px <= n_rest_px;
        r_killed <= n_killed; r_rested <= n_rested; r_traded <= n_traded;
        r_avail <= n_avail; r_idx <= n_idx;
    end

    a_cnt_bid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bid_cnt <= FULL) else $error("bid count overflow");
    a_cnt_ask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ask_cnt <= FULL) else $error("ask count overflow");
    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy) else $error("summary did not end order");
    a_kill_notrade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_killed) |-> (o_filled_qty == 32'd0 && !o_rested))
        else $error("killed order traded");

endmodule
